// ===== hdl/square_matrix_multiply_unit_defines.svh =====
// Assertion macros for the square matrix multiply unit.
// Used by the top level only; no other dependencies.
`ifndef SQUARE_MATRIX_MULTIPLY_UNIT_DEFINES_SVH
`define SQUARE_MATRIX_MULTIPLY_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define SMM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define SMM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/smm_pkg.sv =====
// Shared constants, state encoding and command struct for the
// square matrix multiply unit. No dependencies.
`default_nettype none

package smm_pkg;

	// default parameter values
	localparam int MAX_DIM_DEF   = 8;
	localparam int ELEM_BITS_DEF = 16;

	// fixed port widths
	localparam int IN_W    = 16;
	localparam int CFG_W   = 4;
	localparam int IDX_O_W = 3;
	localparam int OUT_W   = 35;

	// controller states
	typedef enum logic [1:0] {
		ST_LOAD,
		ST_CALC,
		ST_WAIT
	} ctl_state_t;

	// controller to datapath command
	typedef struct packed {
		logic wr_left;
		logic wr_right;
		logic rd_valid;
		logic first;
		logic final_term;
		logic last;
	} dp_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/smm_ifs.sv =====
// Valid/ready channel interfaces for the square matrix multiply unit:
// element input, size register write and product output. Uses smm_pkg.
`default_nettype none

interface smm_elem_if;
	import smm_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [IN_W-1:0]  element_value;
	modport source (output valid, output element_value, input ready);
	modport sink (input valid, input element_value, output ready);
endinterface

interface smm_cfg_if;
	import smm_pkg::*;
	logic              valid;
	logic              ready;
	logic [CFG_W-1:0]  matrix_size;
	modport source (output valid, output matrix_size, input ready);
	modport sink (input valid, input matrix_size, output ready);
endinterface

interface smm_prod_if;
	import smm_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [IDX_O_W-1:0]       out_row;
	logic [IDX_O_W-1:0]       out_col;
	logic signed [OUT_W-1:0]  product_value;
	logic                     last_element;
	modport source (output valid, output out_row, output out_col,
		output product_value, output last_element, input ready);
	modport sink (input valid, input out_row, input out_col,
		input product_value, input last_element, output ready);
endinterface

`default_nettype wire

// ===== hdl/smm_ctrl.sv =====
// Controller of the square matrix multiply unit: size register, load
// counter, row/column/term loop counters and state machine. Uses smm_pkg.
`default_nettype none

module smm_ctrl #(
	parameter int MAX_DIM = smm_pkg::MAX_DIM_DEF,
	localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM),
	localparam int IDX_W  = $clog2(MAX_DIM)
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      elem_valid,
	output logic                           elem_ready,
	input  wire logic                      cfg_valid,
	input  wire logic [smm_pkg::CFG_W-1:0] cfg_data,
	output logic                           cfg_ready,
	input  wire logic                      dp_busy,
	output smm_pkg::dp_cmd_t               cmd,
	output logic [ADDR_W-1:0]              wr_addr,
	output logic [ADDR_W-1:0]              rd_left_addr,
	output logic [ADDR_W-1:0]              rd_right_addr,
	output logic [IDX_W-1:0]               row,
	output logic [IDX_W-1:0]               col
);
	import smm_pkg::*;

	localparam int N_W    = $clog2(MAX_DIM + 1);
	localparam int CELL_W = $clog2(MAX_DIM * MAX_DIM + 1);
	localparam int LC_W   = $clog2(2 * MAX_DIM * MAX_DIM + 1);

	ctl_state_t         state_q, state_d;
	logic [N_W-1:0]     n_q;
	logic [CELL_W-1:0]  cells_q;
	logic [LC_W-1:0]    lc_q;
	logic [IDX_W-1:0]   i_q, j_q, x_q;
	logic [ADDR_W-1:0]  base_q, la_q, ra_q;

	logic               elem_acc, cfg_acc;
	logic [N_W-1:0]     n_new;
	logic [LC_W-1:0]    cells2, lc_eff, lc_inc, right_off;
	logic               in_left, load_done;
	logic [IDX_W-1:0]   nm1;
	logic               x_end, row_end, all_end;

	// handshakes, clamped size and load position
	always_comb begin
		elem_acc  = elem_valid & elem_ready;
		cfg_acc   = cfg_valid & cfg_ready;
		if (cfg_data == '0) begin
			n_new = N_W'(1);
		end else if (cfg_data > CFG_W'(MAX_DIM)) begin
			n_new = N_W'(MAX_DIM);
		end else begin
			n_new = N_W'(cfg_data);
		end
		cells2    = LC_W'(cells_q) << 1;
		lc_eff    = (lc_q >= cells2) ? '0 : lc_q;
		lc_inc    = lc_eff + LC_W'(1);
		in_left   = lc_eff < LC_W'(cells_q);
		right_off = lc_eff - LC_W'(cells_q);
		load_done = !in_left && (lc_inc == cells2);
		nm1       = IDX_W'(n_q - N_W'(1));
		x_end     = (x_q == nm1);
		row_end   = (j_q == nm1);
		all_end   = row_end && (i_q == nm1);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (elem_acc && load_done) state_d = ST_CALC;
			end
			ST_CALC: begin
				if (x_end) state_d = ST_WAIT;
			end
			ST_WAIT: begin
				if (!dp_busy) state_d = all_end ? ST_LOAD : ST_CALC;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// outputs; an offered element goes before a size write
	always_comb begin
		elem_ready     = (state_q == ST_LOAD);
		cfg_ready      = (state_q == ST_LOAD) && !elem_valid;
		cmd.wr_left    = elem_acc & in_left;
		cmd.wr_right   = elem_acc & !in_left;
		cmd.rd_valid   = (state_q == ST_CALC);
		cmd.first      = (x_q == '0);
		cmd.final_term = x_end;
		cmd.last       = all_end;
		wr_addr        = in_left ? lc_eff[ADDR_W-1:0] : right_off[ADDR_W-1:0];
		rd_left_addr   = la_q;
		rd_right_addr  = ra_q;
		row            = i_q;
		col            = j_q;
	end

	// state, size and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			n_q     <= N_W'(MAX_DIM);
			cells_q <= CELL_W'(MAX_DIM * MAX_DIM);
			lc_q    <= '0;
			i_q     <= '0;
			j_q     <= '0;
			x_q     <= '0;
			base_q  <= '0;
			la_q    <= '0;
			ra_q    <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_acc) begin
				n_q     <= n_new;
				cells_q <= CELL_W'(n_new) * CELL_W'(n_new);
				lc_q    <= '0;
			end else if (elem_acc) begin
				lc_q <= load_done ? '0 : lc_inc;
				if (load_done) begin
					i_q    <= '0;
					j_q    <= '0;
					x_q    <= '0;
					base_q <= '0;
					la_q   <= '0;
					ra_q   <= '0;
				end
			end
			// term loop: walk along the left row and down the right column
			if (state_q == ST_CALC) begin
				x_q  <= x_end ? '0 : x_q + IDX_W'(1);
				la_q <= la_q + ADDR_W'(1);
				ra_q <= ra_q + ADDR_W'(n_q);
			end
			// step to the next product element once the last one is out
			if (state_q == ST_WAIT && !dp_busy && !all_end) begin
				if (row_end) begin
					i_q    <= i_q + IDX_W'(1);
					j_q    <= '0;
					base_q <= base_q + ADDR_W'(n_q);
					la_q   <= base_q + ADDR_W'(n_q);
					ra_q   <= '0;
				end else begin
					j_q  <= j_q + IDX_W'(1);
					la_q <= base_q;
					ra_q <= ADDR_W'(j_q) + ADDR_W'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/smm_datapath.sv =====
// Datapath of the square matrix multiply unit: element memories, read
// stage, multiplier, accumulator and output register. Uses smm_pkg.
`default_nettype none

module smm_datapath #(
	parameter int MAX_DIM   = smm_pkg::MAX_DIM_DEF,
	parameter int ELEM_BITS = smm_pkg::ELEM_BITS_DEF,
	localparam int ADDR_W   = $clog2(MAX_DIM * MAX_DIM),
	localparam int IDX_W    = $clog2(MAX_DIM)
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic signed [smm_pkg::IN_W-1:0]  element_value,
	input  wire smm_pkg::dp_cmd_t                 cmd,
	input  wire logic [ADDR_W-1:0]                wr_addr,
	input  wire logic [ADDR_W-1:0]                rd_left_addr,
	input  wire logic [ADDR_W-1:0]                rd_right_addr,
	input  wire logic [IDX_W-1:0]                 row,
	input  wire logic [IDX_W-1:0]                 col,
	output logic                                  busy,
	input  wire logic                             prod_ready,
	output logic                                  prod_valid,
	output logic [smm_pkg::IDX_O_W-1:0]           out_row,
	output logic [smm_pkg::IDX_O_W-1:0]           out_col,
	output logic signed [smm_pkg::OUT_W-1:0]      product_value,
	output logic                                  last_element
);
	import smm_pkg::*;

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int PROD_W = 2 * ELEM_BITS;
	localparam int EXT_W  = (PROD_W > OUT_W) ? PROD_W : OUT_W;

	logic signed [ELEM_BITS-1:0] left_mem_q  [DEPTH];
	logic signed [ELEM_BITS-1:0] right_mem_q [DEPTH];

	logic signed [ELEM_BITS-1:0] elem_w;
	logic signed [ELEM_BITS-1:0] a_s1, b_s1;
	logic                        v_s1, first_s1, final_s1, last_s1;
	logic [IDX_W-1:0]            row_s1, col_s1;
	logic signed [PROD_W-1:0]    prod_s2;
	logic                        v_s2, first_s2, final_s2, last_s2;
	logic [IDX_W-1:0]            row_s2, col_s2;
	logic [OUT_W-1:0]            acc_q, acc_next;
	logic signed [EXT_W-1:0]     prod_ext;
	logic                        out_valid_q, out_last_q;
	logic [IDX_W-1:0]            out_row_q, out_col_q;
	logic [OUT_W-1:0]            out_sum_q;

	// element as stored: low ELEM_BITS bits, signed
	assign elem_w = ELEM_BITS'(element_value);

	// element memories, one write and one registered read each
	always_ff @(posedge clk) begin
		if (cmd.wr_left) left_mem_q[wr_addr] <= elem_w;
		if (cmd.wr_right) right_mem_q[wr_addr] <= elem_w;
		if (cmd.rd_valid) begin
			a_s1 <= left_mem_q[rd_left_addr];
			b_s1 <= right_mem_q[rd_right_addr];
		end
	end

	// payload pipeline: tags, product, accumulator, output data
	always_ff @(posedge clk) begin
		first_s1 <= cmd.first;
		final_s1 <= cmd.final_term;
		last_s1  <= cmd.last;
		row_s1   <= row;
		col_s1   <= col;
		prod_s2  <= a_s1 * b_s1;
		first_s2 <= first_s1;
		final_s2 <= final_s1;
		last_s2  <= last_s1;
		row_s2   <= row_s1;
		col_s2   <= col_s1;
		if (v_s2) begin
			acc_q <= acc_next;
			if (final_s2) begin
				out_sum_q  <= acc_next;
				out_row_q  <= row_s2;
				out_col_q  <= col_s2;
				out_last_q <= last_s2;
			end
		end
	end

	// running sum, wraps at the output width
	always_comb begin
		prod_ext = EXT_W'(prod_s2);
		acc_next = (first_s2 ? '0 : acc_q) + prod_ext[OUT_W-1:0];
	end

	// stage valids and output register full flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= cmd.rd_valid;
			v_s2 <= v_s1;
			if (v_s2 && final_s2) begin
				out_valid_q <= 1'b1;
			end else if (prod_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign busy          = v_s1 | v_s2 | out_valid_q;
	assign prod_valid    = out_valid_q;
	assign out_row       = IDX_O_W'(out_row_q);
	assign out_col       = IDX_O_W'(out_col_q);
	assign product_value = out_sum_q;
	assign last_element  = out_last_q;

endmodule

`default_nettype wire

// ===== hdl/square_matrix_multiply_unit.sv =====
// Square signed integer matrix multiplier, top level.
// Channels: elem (sink) takes matrix elements, left matrix then right
// matrix, each row-major; cfg (sink) writes matrix_size (0 reads as 1,
// values above MAX_DIM read as MAX_DIM) and restarts loading with the
// left matrix; prod (source) gives product elements row-major with row,
// column and a flag on the final one.
// Loading takes one element per cycle, 2*N*N elements for size N.
// Once the last right element is taken, each product element takes N
// memory reads (one left/right pair per cycle through a single
// multiplier); each pair goes through the read and product registers
// and is summed into the output register. Reads for the next element
// start only once the previous result is taken from the output register.
// elem and cfg are not ready while products are being computed or wait
// in the output register; cfg also waits while an element is offered.
// A stalled receiver holds the result and the computation with it.
// Reset returns the size to MAX_DIM and the load position to the first
// left element; element memories are not cleared.
// Depends on smm_pkg, smm_ifs, smm_ctrl, smm_datapath and the defines header.
`default_nettype none
`include "square_matrix_multiply_unit_defines.svh"

module square_matrix_multiply_unit #(
	parameter int MAX_DIM   = smm_pkg::MAX_DIM_DEF,
	parameter int ELEM_BITS = smm_pkg::ELEM_BITS_DEF
) (
	input wire logic    clk,
	input wire logic    arst_n,
	smm_elem_if.sink    elem,
	smm_cfg_if.sink     cfg,
	smm_prod_if.source  prod
);
	import smm_pkg::*;

	localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
	localparam int IDX_W  = $clog2(MAX_DIM);

	dp_cmd_t            cmd_w;
	logic               busy_w;
	logic [ADDR_W-1:0]  wr_addr_w, rd_left_w, rd_right_w;
	logic [IDX_W-1:0]   row_w, col_w;

	// controller
	smm_ctrl #(
		.MAX_DIM(MAX_DIM)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.elem_valid   (elem.valid),
		.elem_ready   (elem.ready),
		.cfg_valid    (cfg.valid),
		.cfg_data     (cfg.matrix_size),
		.cfg_ready    (cfg.ready),
		.dp_busy      (busy_w),
		.cmd          (cmd_w),
		.wr_addr      (wr_addr_w),
		.rd_left_addr (rd_left_w),
		.rd_right_addr(rd_right_w),
		.row          (row_w),
		.col          (col_w)
	);

	// datapath
	smm_datapath #(
		.MAX_DIM  (MAX_DIM),
		.ELEM_BITS(ELEM_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.element_value(elem.element_value),
		.cmd          (cmd_w),
		.wr_addr      (wr_addr_w),
		.rd_left_addr (rd_left_w),
		.rd_right_addr(rd_right_w),
		.row          (row_w),
		.col          (col_w),
		.busy         (busy_w),
		.prod_ready   (prod.ready),
		.prod_valid   (prod.valid),
		.out_row      (prod.out_row),
		.out_col      (prod.out_col),
		.product_value(prod.product_value),
		.last_element (prod.last_element)
	);

	// loading and result delivery never overlap
	`SMM_ASSERT_IMPL(a_no_load_during_output, clk, arst_n, elem.valid && elem.ready, !prod.valid, "element taken while a product waits")
	// a new term read only starts with the output register empty
	`SMM_ASSERT_IMPL(a_read_out_empty, clk, arst_n, cmd_w.rd_valid, !prod.valid, "term read while output register full")
	// memory writes come only from accepted items
	`SMM_ASSERT_IMPL(a_write_on_accept, clk, arst_n, cmd_w.wr_left || cmd_w.wr_right, elem.valid && elem.ready, "element memory written without an accepted item")
	// after the final product is taken the block returns to loading
	`SMM_ASSERT_NEXT(a_back_to_load, clk, arst_n, prod.valid && prod.ready && prod.last_element, ##1 elem.ready, "not ready for elements after the final product")

endmodule

`default_nettype wire
